### sv/spq_pkg.sv
// Package: shared types and codes for the sorted priority queue.
package spq_pkg;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [1:0] ST_INSERTED  = 2'd0;
  localparam logic [1:0] ST_REMOVED   = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [1:0] ST_OVERFLOW  = 2'd3;

  typedef struct packed {
    logic signed [31:0] value;
    logic signed [31:0] prio;
  } entry_t;

  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t item;
  } cell_ctrl_t;

endpackage

### sv/spq_cell.sv
// One slot of the sorted row: holds an entry, shifts right on insert, left on remove.
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  logic               occupied,
  input  logic               left_keep,
  input  spq_pkg::entry_t    left_entry,
  input  spq_pkg::entry_t    right_entry,
  output logic               keep,
  output spq_pkg::entry_t    entry
);
  import spq_pkg::*;

  entry_t entry_next;

  // entry stays in place when its priority is not larger than the new one
  assign keep = occupied && (entry.prio <= ctrl.item.prio);

  always_comb begin
    entry_next = entry;
    if (ctrl.ins) begin
      if (!keep) begin
        entry_next = left_keep ? ctrl.item : left_entry;
      end
    end else if (ctrl.rem) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

### sv/sorted_priority_queue.sv
// Top level: sorted priority queue built as a row of shifting cells.
//
// Input stream s_*: one word per operation. Opcode insert places the value
// after every stored entry of equal or smaller priority (signed compare), so
// equal priorities leave in arrival order. Opcode remove pops the head.
// Output stream m_*: exactly one result word per input word, in order:
// status (inserted, removed, underflow on empty, overflow on full) plus the
// popped value and priority, zero when nothing was popped.
// Every cell compares its priority with the incoming one in parallel and
// takes either its own entry, the new item or a neighbor's entry, so the whole
// row updates at once; the result appears on m_* in the cycle after
// acceptance, and one operation is taken per cycle while the receiver keeps up.
// The result word sits in an output register; s_tready is high while that
// register is empty or being drained, so a stalled receiver holds the input
// after one word is waiting.
// Reset empties the queue (count to zero) and clears m_tvalid; stored
// entries are not cleared.
module sorted_priority_queue #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,  // opcode[0], item_value[32:1], item_priority[64:33]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata   // status[1:0], out_value[33:2], out_priority[65:34]
);
  import spq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic                 in_accept;
  logic                 opcode;
  logic                 full;
  logic                 empty;
  logic [CW-1:0]        count;
  logic [CW-1:0]        count_next;
  cell_ctrl_t           ctrl;
  logic [DEPTH-1:0]     keep;
  entry_t               entries [DEPTH];
  logic [1:0]           status;
  entry_t               result;

  assign s_tready  = !m_tvalid || m_tready;
  assign in_accept = s_tvalid && s_tready;
  assign opcode    = s_tdata[0];
  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);

  assign ctrl.item.value = s_tdata[32:1];
  assign ctrl.item.prio  = s_tdata[64:33];
  assign ctrl.ins = in_accept && (opcode == OP_INSERT) && !full;
  assign ctrl.rem = in_accept && (opcode == OP_REMOVE) && !empty;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic   lk;
      entry_t le;
      entry_t re;
      if (g == 0) begin : g_first
        assign lk = 1'b1;
        assign le = ctrl.item;
      end else begin : g_mid
        assign lk = keep[g-1];
        assign le = entries[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
        assign re = '0;
      end else begin : g_inner
        assign re = entries[g+1];
      end
      spq_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .occupied    (CW'(g) < count),
        .left_keep   (lk),
        .left_entry  (le),
        .right_entry (re),
        .keep        (keep[g]),
        .entry       (entries[g])
      );
    end
  endgenerate

  always_comb begin
    count_next = count;
    if (ctrl.ins) begin
      count_next = count + CW'(1);
    end else if (ctrl.rem) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      count <= count_next;
      if (in_accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      result <= '0;
      unique case (opcode)
        OP_INSERT: status <= full ? ST_OVERFLOW : ST_INSERTED;
        OP_REMOVE: begin
          status <= empty ? ST_UNDERFLOW : ST_REMOVED;
          if (!empty) begin
            result <= entries[0];
          end
        end
        default: status <= ST_INSERTED;
      endcase
    end
  end

  assign m_tdata = {6'b0, result.prio, result.value, status};

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("queue count exceeds depth");

  a_underflow: assert property (@(posedge clk) disable iff (rst)
      in_accept && opcode == OP_REMOVE && empty |=> status == ST_UNDERFLOW && count == '0)
    else $error("remove on empty queue not flagged");

  a_overflow: assert property (@(posedge clk) disable iff (rst)
      in_accept && opcode == OP_INSERT && full |=> status == ST_OVERFLOW && full)
    else $error("insert on full queue not dropped");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
      in_accept && opcode == OP_INSERT && !full |=> count == $past(count) + CW'(1))
    else $error("insert did not grow queue");

endmodule

### tb/testbench.sv
// Testbench: sorted priority queue checked against a shadow sorted list, with random idling and output stalls.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam int QDEPTH = 16;

  typedef struct {
    logic               op;
    logic signed [31:0] val;
    logic signed [31:0] pri;
  } queue_op_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic signed [31:0] val;
    logic signed [31:0] pri;
  } queue_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;

  queue_op_t     pending_ops[$];
  queue_result_t due_results[$];
  int            total_ops = 1;
  int            sent = 0;
  int            received = 0;
  int            errors = 0;

  logic signed [31:0] shadow_val[QDEPTH];
  logic signed [31:0] shadow_prio[QDEPTH];
  int                 shadow_count = 0;

  sorted_priority_queue #(.DEPTH(QDEPTH)) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #1 clk = ~clk;

  // Apply one operation to the shadow list and return the result it yields.
  function automatic queue_result_t shadow_operate(logic op, logic signed [31:0] val,
                                                   logic signed [31:0] pri);
    queue_result_t r;
    int            pos;
    r = '{status: ST_INSERTED, val: '0, pri: '0};
    if (op == OP_INSERT) begin
      if (shadow_count >= QDEPTH) begin
        r.status = ST_OVERFLOW;
      end else begin
        pos = 0;
        while (pos < shadow_count && shadow_prio[pos] <= pri) pos++;
        for (int i = shadow_count; i > pos; i--) begin
          shadow_val[i]  = shadow_val[i-1];
          shadow_prio[i] = shadow_prio[i-1];
        end
        shadow_val[pos]  = val;
        shadow_prio[pos] = pri;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        r.status = ST_UNDERFLOW;
      end else begin
        r.status = ST_REMOVED;
        r.val    = shadow_val[0];
        r.pri    = shadow_prio[0];
        for (int i = 1; i < shadow_count; i++) begin
          shadow_val[i-1]  = shadow_val[i];
          shadow_prio[i-1] = shadow_prio[i];
        end
        shadow_count--;
      end
    end
    return r;
  endfunction

  function automatic void add_op(logic op, logic signed [31:0] val, logic signed [31:0] pri);
    queue_op_t o;
    o.op  = op;
    o.val = val;
    o.pri = pri;
    pending_ops.push_back(o);
  endfunction

  // driver
  always @(posedge clk) begin
    int        gap_pct;
    queue_op_t o;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        due_results.push_back(shadow_operate(s_tdata[0], s_tdata[32:1], s_tdata[64:33]));
        sent++;
      end
      gap_pct = (sent < total_ops / 3) ? 7 : (sent < 2 * total_ops / 3) ? 70 : 0;
      if (!s_tvalid || s_tready) begin
        if (pending_ops.size() > 0 && $urandom_range(99) >= gap_pct) begin
          o = pending_ops.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {7'b0, o.pri, o.val, o.op};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    int            stall_pct;
    queue_result_t exp_r;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        received++;
        if (due_results.size() == 0) begin
          $error("result word with no expectation: %h", m_tdata);
          errors++;
        end else begin
          exp_r = due_results.pop_front();
          if (m_tdata[1:0] !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, m_tdata[1:0]);
            errors++;
          end
          if (m_tdata[33:2] !== exp_r.val) begin
            $error("out_value: expected %0d, got %0d", exp_r.val, $signed(m_tdata[33:2]));
            errors++;
          end
          if (m_tdata[65:34] !== exp_r.pri) begin
            $error("out_priority: expected %0d, got %0d", exp_r.pri,
                   $signed(m_tdata[65:34]));
            errors++;
          end
        end
      end
      stall_pct = (received < total_ops / 3) ? 70 : (received < 2 * total_ops / 3) ? 7 : 0;
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    int                 mode;
    int                 ins_pct;
    logic               op;
    logic signed [31:0] pri;
    logic signed [31:0] extremes[4];

    extremes = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0, -32'sh1};

    // directed: empty pop, fill with ties and extremes, overflow, a few pops
    add_op(OP_REMOVE, $urandom, $urandom);
    add_op(OP_INSERT, 32'sh7fff_ffff, 32'sh0);
    add_op(OP_INSERT, 32'sh8000_0000, 32'sh0);
    add_op(OP_INSERT, 32'sh0, 32'sh7fff_ffff);
    add_op(OP_INSERT, -32'sh1, 32'sh8000_0000);
    add_op(OP_INSERT, 32'sh5, -32'sh1);
    add_op(OP_INSERT, 32'sh6, 32'sh1);
    add_op(OP_INSERT, 32'sh7, 32'sh8000_0000);
    add_op(OP_INSERT, 32'sh8, 32'sh7fff_ffff);
    for (int k = 0; k < 8; k++) add_op(OP_INSERT, $urandom, k - 4);
    add_op(OP_INSERT, -32'sh1, -32'sh1);
    for (int k = 0; k < 4; k++) add_op(OP_REMOVE, $urandom, $urandom);

    // random bursts: fill-heavy, drain-heavy or balanced
    for (int b = 0; b < 43; b++) begin
      mode = $urandom_range(2);
      ins_pct = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
      for (int k = 0; k < 20; k++) begin
        op = ($urandom_range(99) < ins_pct) ? OP_INSERT : OP_REMOVE;
        case ($urandom_range(3))
          0: pri = $signed($urandom_range(6)) - 3;
          1: pri = $urandom;
          2: pri = extremes[$urandom_range(3)];
          default: pri = $urandom_range(15);
        endcase
        add_op(op, $urandom, pri);
      end
    end
    total_ops = pending_ops.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (pending_ops.size() != 0 || s_tvalid) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #200us;
    $display("FAILURE");
    $finish;
  end

endmodule
